FILE: src/bqc_pkg.sv
// types, constants and fixed-point helpers for the biquad cascade
package bqc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int DELAY_W  = 24;
  localparam int PROD_W   = COEF_W + DELAY_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int RND_W    = ACC_W - 14;
  localparam int SLOTS    = 6;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  localparam logic [1:0] CFG_SECTIONS = 2'd0;
  localparam logic [1:0] CFG_GAIN     = 2'd1;

  localparam logic [2:0] SLOT_B0 = 3'd0;
  localparam logic [2:0] SLOT_B1 = 3'd1;
  localparam logic [2:0] SLOT_B2 = 3'd2;
  localparam logic [2:0] SLOT_A0 = 3'd3;
  localparam logic [2:0] SLOT_A1 = 3'd4;
  localparam logic [2:0] SLOT_A2 = 3'd5;

  localparam logic [3:0] ST_RD_A0  = 4'd0;
  localparam logic [3:0] ST_MUL_A0 = 4'd1;
  localparam logic [3:0] ST_MUL_A1 = 4'd2;
  localparam logic [3:0] ST_MUL_A2 = 4'd3;
  localparam logic [3:0] ST_ACC_W  = 4'd4;
  localparam logic [3:0] ST_W      = 4'd5;
  localparam logic [3:0] ST_MUL_B0 = 4'd6;
  localparam logic [3:0] ST_MUL_B1 = 4'd7;
  localparam logic [3:0] ST_MUL_B2 = 4'd8;
  localparam logic [3:0] ST_ACC_Y  = 4'd9;
  localparam logic [3:0] ST_Y      = 4'd10;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_RUN   = 5'b00100,
    S_GAIN  = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  typedef struct packed {
    logic                flag;
    logic [DELAY_W-1:0]  val;
  } sat24_t;

  typedef struct packed {
    logic                flag;
    logic [SAMPLE_W-1:0] val;
  } sat16_t;

  // add half an lsb, then floor shift by 14
  function automatic logic signed [RND_W-1:0] round_q15(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] t;
    t = a + ACC_W'(8192);
    return t[ACC_W-1:14];
  endfunction

  function automatic sat24_t sat24(input logic signed [RND_W-1:0] v);
    sat24_t r;
    if (v > RND_W'(8388607)) begin
      r.flag = 1'b1;
      r.val  = 24'h7fffff;
    end else if (v < -RND_W'(8388608)) begin
      r.flag = 1'b1;
      r.val  = 24'h800000;
    end else begin
      r.flag = 1'b0;
      r.val  = v[DELAY_W-1:0];
    end
    return r;
  endfunction

  function automatic sat16_t sat16(input logic signed [RND_W-1:0] v);
    sat16_t r;
    if (v > RND_W'(32767)) begin
      r.flag = 1'b1;
      r.val  = 16'h7fff;
    end else if (v < -RND_W'(32768)) begin
      r.flag = 1'b1;
      r.val  = 16'h8000;
    end else begin
      r.flag = 1'b0;
      r.val  = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: src/biquad_cascade_iir_filter.sv
// biquad cascade filter: shared multiply-accumulate sequenced over the sections
//
//   channel | direction | signals
//   in      | sink      | in_valid, in_ready, operation, sample_in, section_index,
//           |           | coef_index, coef_value
//   out     | source    | out_valid, out_ready, sample_out, saturated
//   cfg     | sink      | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// a sample transaction runs each active section through the single 18x24 multiplier,
// six products per section; a coefficient transaction is written while the block stays idle
// after reset a clearing pass zeroes the stores, in_ready low
// in_ready is high only while no sample is in flight; a held result does not block input
// a finished sample waits in its last step while the output register is still occupied
module biquad_cascade_iir_filter #(
  parameter int MAX_SECTIONS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 operation,
  input  logic signed [bqc_pkg::SAMPLE_W-1:0]  sample_in,
  input  logic        [2:0]                    section_index,
  input  logic        [2:0]                    coef_index,
  input  logic signed [bqc_pkg::COEF_W-1:0]    coef_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [bqc_pkg::SAMPLE_W-1:0]  sample_out,
  output logic                                 saturated,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [1:0]                    cfg_index,
  input  logic        [bqc_pkg::COEF_W-1:0]    cfg_data
);
  import bqc_pkg::*;

  localparam int CDEPTH = MAX_SECTIONS * SLOTS;
  localparam int DDEPTH = MAX_SECTIONS * 2;
  localparam int CAW    = $clog2(CDEPTH);
  localparam int DAW    = $clog2(DDEPTH);
  localparam int SW     = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  logic signed [COEF_W-1:0]  coef_mem [CDEPTH];
  logic signed [DELAY_W-1:0] delay_mem [DDEPTH];

  state_t                     state;
  logic [3:0]                 step;
  logic [SW-1:0]              sec;
  logic [CAW-1:0]             cbase;
  logic [DAW-1:0]             dbase;
  logic [CAW-1:0]             clr;
  logic [3:0]                 sections;
  logic signed [COEF_W-1:0]   gain;
  logic                       sat_acc;

  logic signed [COEF_W-1:0]   coef_q;
  logic signed [DELAY_W-1:0]  delay_q;
  logic signed [DELAY_W-1:0]  xreg, wreg, w1reg, w2reg;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;

  logic [5:0]                 eff;
  logic [SW-1:0]              last_sec;
  logic [CAW-1:0]             coef_ra;
  logic [DAW-1:0]             delay_ra;
  logic [7:0]                 coef_wa8;
  logic                       coef_we;
  logic                       delay_we;
  logic [DAW-1:0]             delay_wa;
  logic signed [DELAY_W-1:0]  delay_wd;
  logic signed [COEF_W-1:0]   op_c;
  logic signed [DELAY_W-1:0]  op_v;
  logic signed [ACC_W-1:0]    prod_x;
  sat24_t                     acc_sat;
  sat16_t                     out_sat;
  logic                       in_fire;
  logic                       out_free;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign prod_x    = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign acc_sat   = sat24(round_q15(acc));
  assign out_sat   = sat16(round_q15(prod_x));

  // effective section count and last active section
  always_comb begin
    if (sections == 4'd0) begin
      eff = 6'd1;
    end else if (6'(sections) > 6'(MAX_SECTIONS)) begin
      eff = 6'(MAX_SECTIONS);
    end else begin
      eff = 6'(sections);
    end
  end
  assign last_sec = SW'(eff - 6'd1);

  // coefficient write from a transaction
  assign coef_wa8 = 8'(section_index) * 8'd6 + 8'(coef_index);
  assign coef_we  = in_fire && (operation == OP_COEF) && (coef_index <= SLOT_A2) &&
                    (32'(section_index) < MAX_SECTIONS);

  always_comb begin
    case (step)
      ST_RD_A0:  coef_ra = cbase + CAW'(SLOT_A0);
      ST_MUL_A0: coef_ra = cbase + CAW'(SLOT_A1);
      ST_MUL_A1: coef_ra = cbase + CAW'(SLOT_A2);
      ST_W:      coef_ra = cbase + CAW'(SLOT_B0);
      ST_MUL_B0: coef_ra = cbase + CAW'(SLOT_B1);
      ST_MUL_B1: coef_ra = cbase + CAW'(SLOT_B2);
      default:   coef_ra = cbase;
    endcase
  end

  assign delay_ra = (step == ST_MUL_A0) ? dbase + DAW'(1) : dbase;

  always_comb begin
    delay_we = 1'b0;
    delay_wa = dbase;
    delay_wd = wreg;
    if (state == S_CLEAR) begin
      delay_we = (32'(clr) < DDEPTH);
      delay_wa = clr[DAW-1:0];
      delay_wd = '0;
    end else if (state == S_RUN && step == ST_MUL_B0) begin
      delay_we = 1'b1;
      delay_wa = dbase + DAW'(1);
      delay_wd = w1reg;
    end else if (state == S_RUN && step == ST_MUL_B1) begin
      delay_we = 1'b1;
      delay_wa = dbase;
      delay_wd = wreg;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      coef_mem[clr] <= '0;
    end else if (coef_we) begin
      coef_mem[coef_wa8[CAW-1:0]] <= coef_value;
    end
    coef_q <= coef_mem[coef_ra];
  end

  always_ff @(posedge clk) begin
    if (delay_we) begin
      delay_mem[delay_wa] <= delay_wd;
    end
    delay_q <= delay_mem[delay_ra];
  end

  // shared multiplier operands
  always_comb begin
    op_c = coef_q;
    case (step)
      ST_MUL_A0: op_v = xreg;
      ST_MUL_A1: op_v = w1reg;
      ST_MUL_A2: op_v = w2reg;
      ST_MUL_B0: op_v = wreg;
      ST_MUL_B1: op_v = w1reg;
      ST_MUL_B2: op_v = w2reg;
      default:   op_v = xreg;
    endcase
    // gain product held while the result waits
    if (state == S_GAIN || state == S_FIN) begin
      op_c = gain;
      op_v = xreg;
    end
  end

  always_ff @(posedge clk) begin
    prod <= op_c * op_v;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      xreg <= DELAY_W'(sample_in);
    end
    if (state == S_RUN) begin
      case (step)
        ST_MUL_A0: w1reg <= delay_q;
        ST_MUL_A1: begin
          w2reg <= delay_q;
          acc   <= prod_x;
        end
        ST_MUL_A2: acc  <= acc - prod_x;
        ST_ACC_W:  acc  <= acc - prod_x;
        ST_W:      wreg <= acc_sat.val;
        ST_MUL_B1: acc  <= prod_x;
        ST_MUL_B2: acc  <= acc + prod_x;
        ST_ACC_Y:  acc  <= acc + prod_x;
        ST_Y:      xreg <= acc_sat.val;
        default:   acc  <= acc;
      endcase
    end
    if (state == S_FIN && out_free) begin
      sample_out <= out_sat.val;
      saturated  <= sat_acc | out_sat.flag;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      step      <= ST_RD_A0;
      sec       <= '0;
      cbase     <= '0;
      dbase     <= '0;
      clr       <= '0;
      sat_acc   <= 1'b0;
      out_valid <= 1'b0;
      sections  <= 4'd1;
      gain      <= COEF_W'(16384);
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SECTIONS: sections <= cfg_data[3:0];
          CFG_GAIN:     gain     <= cfg_data;
          default:      sections <= sections;
        endcase
      end
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + CAW'(1);
          if (32'(clr) == CDEPTH - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire && operation == OP_SAMPLE) begin
            state   <= S_RUN;
            step    <= ST_RD_A0;
            sec     <= '0;
            cbase   <= '0;
            dbase   <= '0;
            sat_acc <= 1'b0;
          end
        end
        S_RUN: begin
          if (step == ST_W) begin
            sat_acc <= sat_acc | acc_sat.flag;
          end
          if (step == ST_Y) begin
            sat_acc <= sat_acc | acc_sat.flag;
            step    <= ST_RD_A0;
            if (sec == last_sec) begin
              state <= S_GAIN;
            end else begin
              sec   <= sec + SW'(1);
              cbase <= cbase + CAW'(SLOTS);
              dbase <= dbase + DAW'(2);
            end
          end else begin
            step <= step + 4'd1;
          end
        end
        S_GAIN: state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> step <= ST_Y)
    else $error("step counter out of range");

  a_sample_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation == OP_SAMPLE |=>
      state == S_RUN && step == ST_RD_A0 && sec == '0)
    else $error("sample transaction did not start at section zero");

  a_coef_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation == OP_COEF |=> state == S_IDLE)
    else $error("coefficient transaction left idle");

  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && out_valid && !out_ready |=> state == S_FIN && out_valid)
    else $error("result overwrote a pending output");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && (!out_valid || out_ready) |=> out_valid && state == S_IDLE)
    else $error("finished sample not delivered");
`endif

endmodule

FILE: tb/tb_biquad_cascade_iir_filter.sv
// testbench for the biquad cascade filter: predicted outputs checked against every output transaction
module tb_biquad_cascade_iir_filter;
  import bqc_pkg::*;

  localparam int N_SECT     = 8;
  localparam int RAND_ITEMS = 1350;
  localparam int SETTLE     = 16;
  localparam int IDLE_LIMIT = 4000;

  localparam longint DELAY_MAX = 8388607;
  localparam longint DELAY_MIN = -8388608;
  localparam longint OUT_MAX   = 32767;
  localparam longint OUT_MIN   = -32768;

  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;
  localparam logic [2:0] SLOT_NONE_A = 3'd6;
  localparam logic [2:0] SLOT_NONE_B = 3'd7;

  typedef struct {
    logic                       op;
    logic signed [SAMPLE_W-1:0] smp;
    logic [2:0]                 sec;
    logic [2:0]                 slot;
    logic signed [COEF_W-1:0]   val;
  } filt_item_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       sat;
  } filt_result_t;

  class cascade_checker;
    logic signed [COEF_W-1:0]  coefs [N_SECT*SLOTS];
    logic signed [DELAY_W-1:0] delays [N_SECT*2];
    logic [3:0]                n_sections;
    logic signed [COEF_W-1:0]  gain;
    filt_result_t              expected_q [$];
    int                        errors;

    function new();
      foreach (coefs[i]) coefs[i] = '0;
      foreach (delays[i]) delays[i] = '0;
      n_sections = 4'd1;
      gain = COEF_W'(16384);
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [COEF_W-1:0] data);
      case (idx)
        CFG_SECTIONS: n_sections = data[3:0];
        CFG_GAIN:     gain = data;
        default: ;
      endcase
    endfunction

    // add half an lsb, floor to q.15
    function longint to_q15(longint acc);
      return (acc + 64'sd8192) >>> 14;
    endfunction

    function longint clip(longint v, longint lim_lo, longint lim_hi, inout bit hit);
      if (v > lim_hi) begin
        hit = 1'b1;
        return lim_hi;
      end
      if (v < lim_lo) begin
        hit = 1'b1;
        return lim_lo;
      end
      return v;
    endfunction

    function void apply_input(filt_item_t it);
      int           count;
      int           base;
      int           s;
      longint       x, w, w1, w2, acc;
      bit           sat;
      filt_result_t r;
      if (it.op == OP_COEF) begin
        if (it.slot < SLOTS && it.sec < N_SECT)
          coefs[it.sec * SLOTS + it.slot] = it.val;
        return;
      end
      count = int'(n_sections);
      if (count < 1) count = 1;
      if (count > N_SECT) count = N_SECT;
      sat = 1'b0;
      x = longint'(it.smp);
      for (s = 0; s < count; s++) begin
        base = s * SLOTS;
        w1 = longint'(delays[2*s]);
        w2 = longint'(delays[2*s+1]);
        acc = longint'(coefs[base + SLOT_A0]) * x - longint'(coefs[base + SLOT_A1]) * w1
            - longint'(coefs[base + SLOT_A2]) * w2;
        w = clip(to_q15(acc), DELAY_MIN, DELAY_MAX, sat);
        acc = longint'(coefs[base + SLOT_B0]) * w + longint'(coefs[base + SLOT_B1]) * w1
            + longint'(coefs[base + SLOT_B2]) * w2;
        x = clip(to_q15(acc), DELAY_MIN, DELAY_MAX, sat);
        delays[2*s+1] = w1[DELAY_W-1:0];
        delays[2*s]   = w[DELAY_W-1:0];
      end
      r.smp = SAMPLE_W'(clip(to_q15(longint'(gain) * x), OUT_MIN, OUT_MAX, sat));
      r.sat = sat;
      expected_q.push_back(r);
    endfunction

    function void check_output(logic signed [SAMPLE_W-1:0] smp, logic sat);
      filt_result_t e;
      if (expected_q.size() == 0) begin
        $error("sample_out unexpected transaction, actual %0d saturated %0b", smp, sat);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (smp !== e.smp) begin
        $error("sample_out expected %0d actual %0d", e.smp, smp);
        errors++;
      end
      if (sat !== e.sat) begin
        $error("saturated expected %0b actual %0b", e.sat, sat);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                       clk           = 1'b0;
  logic                       rst           = 1'b1;
  logic                       in_valid      = 1'b0;
  logic                       in_ready;
  logic                       operation     = OP_SAMPLE;
  logic signed [SAMPLE_W-1:0] sample_in     = '0;
  logic [2:0]                 section_index = '0;
  logic [2:0]                 coef_index    = '0;
  logic signed [COEF_W-1:0]   coef_value    = '0;
  logic                       out_valid;
  logic                       out_ready     = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       saturated;
  logic                       cfg_valid     = 1'b0;
  logic                       cfg_ready;
  logic [1:0]                 cfg_index     = '0;
  logic [COEF_W-1:0]          cfg_data      = '0;

  cascade_checker sb;
  filt_item_t     plan [$];
  bit             no_idle = 1'b0;
  int             idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  biquad_cascade_iir_filter #(
    .MAX_SECTIONS(N_SECT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .sample_in(sample_in),
    .section_index(section_index),
    .coef_index(coef_index),
    .coef_value(coef_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sample_out(sample_out),
    .saturated(saturated),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function automatic filt_item_t sample_item(logic signed [SAMPLE_W-1:0] v);
    filt_item_t it;
    it.op   = OP_SAMPLE;
    it.smp  = v;
    it.sec  = 3'($urandom);
    it.slot = 3'($urandom);
    it.val  = COEF_W'($urandom);
    return it;
  endfunction

  function automatic filt_item_t coef_item(logic [2:0] sec, logic [2:0] slot,
                                           logic signed [COEF_W-1:0] v);
    filt_item_t it;
    it.op   = OP_COEF;
    it.smp  = SAMPLE_W'($urandom);
    it.sec  = sec;
    it.slot = slot;
    it.val  = v;
    return it;
  endfunction

  // bounds keep each section stable
  function automatic logic signed [COEF_W-1:0] stable_coef(logic [2:0] slot);
    case (slot)
      SLOT_A0: return COEF_W'($urandom_range(8192, 16384));
      SLOT_A1: return COEF_W'(int'($urandom_range(0, 16000)) - 8000);
      SLOT_A2: return COEF_W'(int'($urandom_range(0, 20000)) - 8000);
      default: return COEF_W'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic signed [SAMPLE_W-1:0] v;
    v = SAMPLE_W'($urandom);
    if ($urandom_range(0, 3) != 0) v = v >>> $urandom_range(1, 6);
    return v;
  endfunction

  task automatic send_item(filt_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= it.op;
    sample_in     <= it.smp;
    section_index <= it.sec;
    coef_index    <= it.slot;
    coef_value    <= it.val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg_tx(logic [1:0] idx, logic [COEF_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_plan();
    foreach (plan[i]) send_item(plan[i]);
    in_valid <= 1'b0;
    plan.delete();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int n_done;
    while (rst) @(posedge clk);
    forever begin
      n_done = no_idle ? 0 : $urandom_range(0, 6);
      if (n_done > 0) begin
        out_ready <= 1'b0;
        repeat (n_done) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.apply_input('{operation, sample_in, section_index, coef_index, coef_value});
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (out_valid && out_ready) sb.check_output(sample_out, saturated);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[biquad_cascade_iir_filter] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int                n_done;
    int                n_run;
    int                pick;
    int                s;
    int                k;
    logic [2:0]        slot;
    logic [3:0]        sec_cfg;
    logic [COEF_W-1:0] gain_cfg;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero coefficients, identity section, ignored slots, extreme coefficients
    plan.push_back(sample_item(16'sd0));
    plan.push_back(sample_item(16'sd32767));
    plan.push_back(coef_item(3'd0, SLOT_B0, 18'sd16384));
    plan.push_back(coef_item(3'd0, SLOT_A0, 18'sd16384));
    plan.push_back(coef_item(3'd0, SLOT_NONE_A, 18'sd131071));
    plan.push_back(coef_item(3'd0, SLOT_NONE_B, -18'sd131072));
    plan.push_back(sample_item(16'sd32767));
    plan.push_back(sample_item(-16'sd32768));
    plan.push_back(sample_item(-16'sd1));
    plan.push_back(coef_item(3'd0, SLOT_A0, 18'sd131071));
    plan.push_back(coef_item(3'd0, SLOT_B0, 18'sd131071));
    plan.push_back(sample_item(-16'sd32768));
    plan.push_back(sample_item(16'sd32767));
    plan.push_back(coef_item(3'd0, SLOT_A1, -18'sd131072));
    plan.push_back(coef_item(3'd0, SLOT_A2, 18'sd131071));
    plan.push_back(sample_item(16'sd32767));
    plan.push_back(sample_item(-16'sd32768));
    run_plan();

    // zero section count, most negative gain, unmapped registers
    write_reg_tx(CFG_SECTIONS, '0);
    write_reg_tx(CFG_GAIN, COEF_W'(-131072));
    write_reg_tx(CFG_SPARE_A, '1);
    write_reg_tx(CFG_SPARE_B, COEF_W'(5));
    plan.push_back(sample_item(16'sd32767));
    plan.push_back(sample_item(-16'sd32768));
    plan.push_back(sample_item(16'sd1));
    run_plan();

    // oversized section count, largest gain
    write_reg_tx(CFG_SECTIONS, '1);
    write_reg_tx(CFG_GAIN, COEF_W'(131071));
    plan.push_back(coef_item(3'd7, SLOT_B2, -18'sd131072));
    plan.push_back(sample_item(16'sd32767));
    plan.push_back(sample_item(-16'sd32768));
    run_plan();

    n_done = 0;
    while (n_done < RAND_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 14);
      case (pick)
        0:       sec_cfg = 4'd0;
        1:       sec_cfg = 4'd8;
        2:       sec_cfg = 4'd15;
        3:       sec_cfg = 4'($urandom_range(9, 14));
        default: sec_cfg = 4'($urandom_range(1, 4));
      endcase
      n_run = (sec_cfg == 0) ? 1 : ((sec_cfg > N_SECT) ? N_SECT : sec_cfg);
      write_reg_tx(CFG_SECTIONS, {14'($urandom), sec_cfg});
      pick = $urandom_range(0, 5);
      case (pick)
        0:       gain_cfg = COEF_W'(-131072);
        1:       gain_cfg = COEF_W'(131071);
        2:       gain_cfg = COEF_W'(16384);
        3:       gain_cfg = COEF_W'($urandom);
        default: gain_cfg = COEF_W'(int'($urandom_range(0, 49152)) - 16384);
      endcase
      write_reg_tx(CFG_GAIN, gain_cfg);
      if ($urandom_range(0, 4) == 0)
        write_reg_tx($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, COEF_W'($urandom));

      for (s = 0; s < n_run; s++) begin
        if ($urandom_range(0, 2) != 0) begin
          for (k = 0; k < SLOTS; k++) begin
            slot = 3'(k);
            plan.push_back(coef_item(3'(s), slot, stable_coef(slot)));
          end
        end
      end
      repeat ($urandom_range(40, 120)) begin
        pick = $urandom_range(0, 19);
        if (pick < 17) begin
          plan.push_back(sample_item(rand_sample()));
        end else if (pick < 19) begin
          slot = 3'($urandom_range(0, SLOTS - 1));
          plan.push_back(coef_item(3'($urandom), slot, stable_coef(slot)));
        end else begin
          plan.push_back(coef_item(3'($urandom), 3'($urandom), COEF_W'($urandom)));
        end
      end
      foreach (plan[i])
        if (plan[i].op == OP_SAMPLE || plan[i].slot < SLOTS) n_done++;
      run_plan();
    end

    if (sb.errors == 0 && sb.pending() == 0)
      $display("[biquad_cascade_iir_filter] OK");
    else
      $display("[biquad_cascade_iir_filter] ERROR");
    $finish;
  end

endmodule
